// File: rtl/core/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants and beat types for the closed tour squared length core.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

	localparam int MAX_CITIES = 1024;
	localparam int COORD_BITS = 16;
	localparam int CITY_W     = 10;
	localparam int ADDR_W     = $clog2(MAX_CITIES);
	localparam int COST_W     = 42;
	localparam int COUNT_W    = 11;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int EDGE_W     = SQ_W + 2;
	localparam int ENTRY_W    = 2 * COORD_BITS;

	localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TOUR = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIFF_W-1:0]            mag_t;
	typedef logic [SQ_W-1:0]              sq_t;
	typedef logic [EDGE_W-1:0]            edge_t;
	typedef logic [COST_W-1:0]            cost_t;
	typedef logic [COUNT_W-1:0]           count_t;

endpackage

`default_nettype wire

// File: rtl/core/cts_req_if.sv
// ----------------------------------------------------------------------------
// cts_req_if
// Request channel: coordinate loads and tour entries.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_req_if;
	import cts_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [CITY_W-1:0]            city;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic                         last;

	modport source (output valid, opcode, city, pos_x, pos_y, last, input ready);
	modport sink (input valid, opcode, city, pos_x, pos_y, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cts_rsp_if.sv
// ----------------------------------------------------------------------------
// cts_rsp_if
// Result channel: closed tour cost and entry count.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_rsp_if;
	import cts_pkg::*;

	logic               valid;
	logic               ready;
	logic [COST_W-1:0]  total_cost;
	logic [COUNT_W-1:0] tour_length;

	modport source (output valid, total_cost, tour_length, input ready);
	modport sink (input valid, total_cost, tour_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cts_ram.sv
// ----------------------------------------------------------------------------
// cts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/closed_tour_squared_length_core.sv
// ----------------------------------------------------------------------------
// closed_tour_squared_length_core
// Sums squared edge lengths of a closed tour over a coordinate table in RAM.
// ----------------------------------------------------------------------------
//  channel  role  payload
//  req      sink  opcode, city, pos_x, pos_y, last
//  rsp      src   total_cost, tour_length
//
//  One beat per cycle while req is not stalled, loads and tour entries alike;
//  a result is registered behind the RAM read at the accepting edge through
//  the square stage, the edge sum stage and the accumulator. The per-tour
//  state is reset by arst_n; the table is not cleared. A pending result
//  stalls req only when a further result reaches the accumulator stage.
// ----------------------------------------------------------------------------
`default_nettype none

module closed_tour_squared_length_core (
	input wire   clk,
	input wire   arst_n,
	cts_req_if.sink   req,
	cts_rsp_if.source rsp
);
	import cts_pkg::*;

	logic                advance;
	logic                req_fire;
	logic [ENTRY_W-1:0]  rd_entry;
	logic                in_range;

	logic                valid_s1, last_s1, inrange_s1;
	logic                valid_s2, last_s2, first_s2;
	sq_t                 sqx_s2, sqy_s2, cqx_s2, cqy_s2;
	count_t              count_s2;
	logic                valid_s3, last_s3, multi_s3;
	edge_t               edge_s3;
	count_t              count_s3;

	coord_t              first_x_q, first_y_q, prev_x_q, prev_y_q;
	count_t              count_q;
	cost_t               cost_q;
	logic                out_valid_q;
	cost_t               out_cost_q;
	count_t              out_count_q;

	coord_t              cx, cy;
	logic                is_first;
	count_t              count_next;
	logic [COST_W:0]     cost_sum;
	cost_t               cost_sat;
	logic [SQ_W:0]       step_sum, close_sum;

	function automatic mag_t abs_diff(coord_t a, coord_t b);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(a) - DIFF_W'(b);
		return d[DIFF_W-1] ? mag_t'(-d) : mag_t'(d);
	endfunction

	assign advance  = !(out_valid_q && !rsp.ready && valid_s3 && last_s3);
	assign req.ready = advance;
	assign req_fire = req.valid && advance;
	assign in_range = 32'(req.city) < 32'(MAX_CITIES);

	cts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_CITIES)
	) u_coord_ram (
		.clk  (clk),
		.we   (req_fire && req.opcode == OP_LOAD && in_range),
		.waddr(ADDR_W'(req.city)),
		.wdata({req.pos_y[COORD_BITS-1:0], req.pos_x[COORD_BITS-1:0]}),
		.re   (req_fire && req.opcode == OP_TOUR),
		.raddr(ADDR_W'(req.city)),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			inrange_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1   <= req_fire && req.opcode == OP_TOUR;
			last_s1    <= req.last;
			inrange_s1 <= in_range;
		end
	end

	// Stage 1: pick up the city, square the edge and closing deltas.
	assign cx         = inrange_s1 ? coord_t'(rd_entry[COORD_BITS-1:0]) : '0;
	assign cy         = inrange_s1 ? coord_t'(rd_entry[ENTRY_W-1:COORD_BITS]) : '0;
	assign is_first   = count_q == '0;
	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			count_q   <= '0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (last_s1) begin
					first_x_q <= '0;
					first_y_q <= '0;
					prev_x_q  <= '0;
					prev_y_q  <= '0;
					count_q   <= '0;
				end else begin
					if (is_first) begin
						first_x_q <= cx;
						first_y_q <= cy;
					end
					prev_x_q <= cx;
					prev_y_q <= cy;
					count_q  <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s2  <= last_s1;
			first_s2 <= is_first;
			count_s2 <= count_next;
			sqx_s2   <= SQ_W'(abs_diff(prev_x_q, cx) * abs_diff(prev_x_q, cx));
			sqy_s2   <= SQ_W'(abs_diff(prev_y_q, cy) * abs_diff(prev_y_q, cy));
			cqx_s2   <= SQ_W'(abs_diff(cx, first_x_q) * abs_diff(cx, first_x_q));
			cqy_s2   <= SQ_W'(abs_diff(cy, first_y_q) * abs_diff(cy, first_y_q));
		end
	end

	// Stage 2: combine the step edge and, on the last entry, the closing edge.
	assign step_sum  = first_s2 ? '0 : {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign close_sum = (last_s2 && !first_s2) ? {1'b0, cqx_s2} + {1'b0, cqy_s2} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s3  <= last_s2;
			multi_s3 <= !first_s2;
			count_s3 <= count_s2;
			edge_s3  <= EDGE_W'(step_sum) + EDGE_W'(close_sum);
		end
	end

	// Stage 3: saturating accumulate, hand the total to the result register.
	assign cost_sum = {1'b0, cost_q} + (COST_W + 1)'(edge_s3);
	assign cost_sat = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && valid_s3) begin
				if (last_s3) begin
					cost_q      <= '0;
					out_valid_q <= 1'b1;
				end else begin
					cost_q <= cost_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s3 && last_s3) begin
			out_cost_q  <= multi_s3 ? cost_sat : '0;
			out_count_q <= count_s3;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.total_cost  = out_cost_q;
	assign rsp.tour_length = out_count_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> out_valid_q && valid_s3 && last_s3)
		else $error("req stalled without a blocked result");

	a_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s3 && last_s3 && !multi_s3 |=> rsp.valid && rsp.total_cost == '0)
		else $error("single entry tour gave nonzero cost");

	a_tour_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && last_s1 |=> count_q == '0)
		else $error("entry count not cleared after last entry");

	a_cost_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s3 && last_s3 |=> cost_q == '0)
		else $error("accumulator not cleared after result");

endmodule

`default_nettype wire
